/* rtl/tpgq_pkg.sv */
package tpgq_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_GATE_LOW          = 3'd0,
		REG_GATE_HIGH         = 3'd1,
		REG_PEAK_WIN_START    = 3'd2,
		REG_PEAK_WIN_END      = 3'd3,
		REG_PULSE_THRESHOLD   = 3'd4,
		REG_PULSE_WIN_START   = 3'd5,
		REG_PULSE_WIN_END     = 3'd6,
		REG_UNUSED            = 3'd7
	} reg_index_t;

	localparam int AMP_W   = 12;
	localparam int WIN_W   = 11;
	localparam int COUNT_W = 8;
	localparam int TOTAL_W = 32;
	// Signed compare width: covers a 16-bit sample doubled, plus a 12-bit threshold
	localparam int CMP_W   = 18;

	localparam logic [AMP_W-1:0]   PEAK_MAX  = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [AMP_W-1:0] GATE_LOW_RST        = 12'd950;
	localparam logic [AMP_W-1:0] GATE_HIGH_RST       = 12'd1350;
	localparam logic [WIN_W-1:0] PEAK_WIN_START_RST  = 11'd1050;
	localparam logic [WIN_W-1:0] PEAK_WIN_END_RST    = 11'd1250;
	localparam logic [AMP_W-1:0] PULSE_THRESHOLD_RST = 12'd200;
	localparam logic [WIN_W-1:0] PULSE_WIN_START_RST = 11'd800;
	localparam logic [WIN_W-1:0] PULSE_WIN_END_RST   = 11'd1500;

	// Output tdata width
	localparam int OUT_DATA_W = 120;

endpackage

/* rtl/trace_pulse_gate_qualifier.sv */
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: sample; s_tlast: last_sample
// m_*       out        m_tvalid / m_tready  m_tdata: peak, count, totals; m_tuser: flags
// cfg_*     in         cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// One sample per clock sustained, but for the stall described below. A sample
// is taken into the input stage, then its compares and running max update the
// trace state in the next cycle. The result of a trace is captured in the output
// register as its last sample leaves the input stage. Reset restores register
// defaults and clears all trace state and totals. A stalled output only holds
// back the input once a second last sample is waiting behind an untaken result.
module trace_pulse_gate_qualifier #(
	parameter int TRACE_LEN   = 2048,
	parameter int SAMPLE_BITS = 13
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// sample input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // [SAMPLE_BITS-1:0] sample
	input  logic                                  s_tlast,  // last_sample
	// trace result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [11:0] trace_peak, [19:12] pulse_count, [51:20] traces_seen,
	// [83:52] single_seen, [115:84] gated_seen, [119:116] zero
	output logic [tpgq_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic [1:0]                            m_tuser,  // [0] single_pulse, [1] in_gate
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [2:0]                            cfg_index,
	input  logic [tpgq_pkg::AMP_W-1:0]            cfg_data
);

	localparam int BIN_W  = $clog2(TRACE_LEN + 1);
	localparam int BWIN_W = (BIN_W > tpgq_pkg::WIN_W) ? BIN_W : tpgq_pkg::WIN_W;
	localparam int AW = tpgq_pkg::AMP_W;
	localparam int WW = tpgq_pkg::WIN_W;
	localparam int CW = tpgq_pkg::COUNT_W;
	localparam int TW = tpgq_pkg::TOTAL_W;
	localparam int XW = tpgq_pkg::CMP_W;

	// configuration registers
	logic [AW-1:0] gate_low_q, gate_high_q, threshold_q;
	logic [WW-1:0] peak_start_q, peak_end_q, pulse_start_q, pulse_end_q;

	// input stage
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          last_s1;

	// per-trace state and totals
	logic [BIN_W-1:0] bin_q;
	logic [AW-1:0]    peak_q;
	logic             armed_q;
	logic [CW-1:0]    pulses_q;
	logic [TW-1:0]    trace_total_q, single_total_q, gated_total_q;

	// output register
	logic          m_valid_q;
	logic [AW-1:0] out_peak_q;
	logic [CW-1:0] out_count_q;
	logic          out_single_q, out_gated_q;
	logic [TW-1:0] out_traces_q, out_single_tot_q, out_gated_tot_q;

	// next-state logic
	logic          proc;
	logic [BIN_W-1:0] bin_nx;
	logic [AW-1:0] peak_nx;
	logic          armed_nx;
	logic [CW-1:0] pulses_nx;
	logic          single, gated;
	logic [TW-1:0] trace_tot_nx, single_tot_nx, gated_tot_nx;

	// Advance the input stage unless its result would overwrite one still waiting
	assign proc      = valid_s1 && (!last_s1 || !m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || proc;
	assign cfg_ready = 1'b1;

	always_comb begin
		logic              bin_ok;
		logic [BWIN_W-1:0] bin_w;
		logic signed [XW-1:0] s_ext;
		logic signed [XW-1:0] thr_ext;
		logic [AW-1:0]     s_clip;
		bin_ok  = bin_q < BIN_W'(TRACE_LEN);
		bin_w   = BWIN_W'(bin_q);
		s_ext   = XW'(sample_s1);
		thr_ext = signed'(XW'(threshold_q));
		s_clip  = (s_ext > signed'(XW'(tpgq_pkg::PEAK_MAX))) ? tpgq_pkg::PEAK_MAX
		                                                      : s_ext[AW-1:0];
		peak_nx   = peak_q;
		armed_nx  = armed_q;
		pulses_nx = pulses_q;
		bin_nx    = bin_ok ? bin_q + 1'b1 : bin_q;

		// running max over the peak window, floored at zero
		if (bin_ok && bin_w >= BWIN_W'(peak_start_q) && bin_w <= BWIN_W'(peak_end_q)
		    && s_ext > 0 && s_clip > peak_q) begin
			peak_nx = s_clip;
		end

		// hysteresis discriminator: arm above threshold, release below half
		if (bin_ok && bin_w >= BWIN_W'(pulse_start_q) && bin_w <= BWIN_W'(pulse_end_q)) begin
			if (!armed_q && s_ext > thr_ext) begin
				armed_nx = 1'b1;
				if (pulses_q != tpgq_pkg::COUNT_MAX) begin
					pulses_nx = pulses_q + 1'b1;
				end
			end else if (armed_q && (s_ext <<< 1) < thr_ext) begin
				armed_nx = 1'b0;
			end
		end

		single = pulses_nx == CW'(1);
		gated  = single && peak_nx >= gate_low_q && peak_nx <= gate_high_q;
		trace_tot_nx  = (trace_total_q == tpgq_pkg::TOTAL_MAX) ? trace_total_q
		                                                       : trace_total_q + 1'b1;
		single_tot_nx = (single && single_total_q != tpgq_pkg::TOTAL_MAX)
		                ? single_total_q + 1'b1 : single_total_q;
		gated_tot_nx  = (gated && gated_total_q != tpgq_pkg::TOTAL_MAX)
		                ? gated_total_q + 1'b1 : gated_total_q;
	end

	// configuration writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_low_q    <= tpgq_pkg::GATE_LOW_RST;
			gate_high_q   <= tpgq_pkg::GATE_HIGH_RST;
			peak_start_q  <= tpgq_pkg::PEAK_WIN_START_RST;
			peak_end_q    <= tpgq_pkg::PEAK_WIN_END_RST;
			threshold_q   <= tpgq_pkg::PULSE_THRESHOLD_RST;
			pulse_start_q <= tpgq_pkg::PULSE_WIN_START_RST;
			pulse_end_q   <= tpgq_pkg::PULSE_WIN_END_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (tpgq_pkg::reg_index_t'(cfg_index))
				tpgq_pkg::REG_GATE_LOW:        gate_low_q    <= cfg_data;
				tpgq_pkg::REG_GATE_HIGH:       gate_high_q   <= cfg_data;
				tpgq_pkg::REG_PEAK_WIN_START:  peak_start_q  <= cfg_data[WW-1:0];
				tpgq_pkg::REG_PEAK_WIN_END:    peak_end_q    <= cfg_data[WW-1:0];
				tpgq_pkg::REG_PULSE_THRESHOLD: threshold_q   <= cfg_data;
				tpgq_pkg::REG_PULSE_WIN_START: pulse_start_q <= cfg_data[WW-1:0];
				tpgq_pkg::REG_PULSE_WIN_END:   pulse_end_q   <= cfg_data[WW-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
			last_s1   <= s_tlast;
		end
	end

	// trace state: update per sample, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q          <= '0;
			peak_q         <= '0;
			armed_q        <= 1'b0;
			pulses_q       <= '0;
			trace_total_q  <= '0;
			single_total_q <= '0;
			gated_total_q  <= '0;
		end else if (proc) begin
			if (last_s1) begin
				bin_q          <= '0;
				peak_q         <= '0;
				armed_q        <= 1'b0;
				pulses_q       <= '0;
				trace_total_q  <= trace_tot_nx;
				single_total_q <= single_tot_nx;
				gated_total_q  <= gated_tot_nx;
			end else begin
				bin_q    <= bin_nx;
				peak_q   <= peak_nx;
				armed_q  <= armed_nx;
				pulses_q <= pulses_nx;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			out_peak_q       <= peak_nx;
			out_count_q      <= pulses_nx;
			out_single_q     <= single;
			out_gated_q      <= gated;
			out_traces_q     <= trace_tot_nx;
			out_single_tot_q <= single_tot_nx;
			out_gated_tot_q  <= gated_tot_nx;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, out_gated_tot_q, out_single_tot_q, out_traces_q,
	                   out_count_q, out_peak_q};
	assign m_tuser  = {out_gated_q, out_single_q};

	// an armed discriminator has always counted at least one pulse
	a_armed_counted: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> pulses_q != '0)
		else $error("armed with zero pulses");

	// totals stay ordered: gated <= single <= traces
	a_totals_order: assert property (@(posedge clk) disable iff (!arst_n)
		gated_total_q <= single_total_q && single_total_q <= trace_total_q)
		else $error("running totals out of order");

	// gate flag only on a single-pulse result
	a_gate_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && out_gated_q |-> out_single_q)
		else $error("in_gate without single_pulse");

	// a result appears only after a last sample was processed
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(proc && last_s1))
		else $error("result without last sample");

	// the bin counter never runs past the trace length
	a_bin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bin_q <= BIN_W'(TRACE_LEN))
		else $error("bin index past trace length");

endmodule

/* tb/sv/trace_pulse_gate_qualifier_test.sv */
module trace_pulse_gate_qualifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W   = 13;
	localparam int S_DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
	localparam int TRACE_BINS = 2048;
	// Cycles to let the pipeline empty after the last result before a register write
	localparam int SETTLE_CYCLES = 4;
	// Length of the long receiver hold-off, in cycles
	localparam int RX_HOLD_CYCLES = 400;

	// One trace summary as it leaves the block
	typedef struct {
		logic [tpgq_pkg::AMP_W-1:0]   peak;
		logic [tpgq_pkg::COUNT_W-1:0] count;
		logic                         single;
		logic                         gated;
		logic [tpgq_pkg::TOTAL_W-1:0] traces;
		logic [tpgq_pkg::TOTAL_W-1:0] singles;
		logic [tpgq_pkg::TOTAL_W-1:0] gateds;
	} trace_summary_t;

	// Tracks the register file and per-trace state of the block, predicts each
	// trace summary and compares the block's summaries against them in order.
	class trace_scoreboard;
		logic [tpgq_pkg::AMP_W-1:0]   gate_low, gate_high, threshold;
		logic [tpgq_pkg::WIN_W-1:0]   peak_start, peak_end, pulse_start, pulse_end;
		int                           bin_pos;
		logic [tpgq_pkg::AMP_W-1:0]   peak_run;
		bit                           armed;
		logic [tpgq_pkg::COUNT_W-1:0] pulses;
		logic [tpgq_pkg::TOTAL_W-1:0] trace_total, single_total, gated_total;
		trace_summary_t               summaries_due[$];
		int                           mismatches, summaries_checked, single_summaries, gated_summaries;

		function new();
			gate_low     = tpgq_pkg::GATE_LOW_RST;
			gate_high    = tpgq_pkg::GATE_HIGH_RST;
			peak_start   = tpgq_pkg::PEAK_WIN_START_RST;
			peak_end     = tpgq_pkg::PEAK_WIN_END_RST;
			threshold    = tpgq_pkg::PULSE_THRESHOLD_RST;
			pulse_start  = tpgq_pkg::PULSE_WIN_START_RST;
			pulse_end    = tpgq_pkg::PULSE_WIN_END_RST;
			trace_total  = '0;
			single_total = '0;
			gated_total  = '0;
			clear_trace();
		endfunction

		function void clear_trace();
			bin_pos  = 0;
			peak_run = '0;
			armed    = 1'b0;
			pulses   = '0;
		endfunction

		// Mirror a register write; window registers keep only their low 11 bits
		function void set_register(tpgq_pkg::reg_index_t idx, logic [tpgq_pkg::AMP_W-1:0] value);
			case (idx)
				tpgq_pkg::REG_GATE_LOW:        gate_low    = value;
				tpgq_pkg::REG_GATE_HIGH:       gate_high   = value;
				tpgq_pkg::REG_PEAK_WIN_START:  peak_start  = value[tpgq_pkg::WIN_W-1:0];
				tpgq_pkg::REG_PEAK_WIN_END:    peak_end    = value[tpgq_pkg::WIN_W-1:0];
				tpgq_pkg::REG_PULSE_THRESHOLD: threshold   = value;
				tpgq_pkg::REG_PULSE_WIN_START: pulse_start = value[tpgq_pkg::WIN_W-1:0];
				tpgq_pkg::REG_PULSE_WIN_END:   pulse_end   = value[tpgq_pkg::WIN_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [tpgq_pkg::TOTAL_W-1:0] bump(logic [tpgq_pkg::TOTAL_W-1:0] v);
			return (v == tpgq_pkg::TOTAL_MAX) ? v : v + 1'b1;
		endfunction

		// Advance the trace state by one accepted sample; queue a summary on the last one
		function void note_sample(logic [SAMPLE_W-1:0] raw, bit last);
			int             s, thr;
			bit             in_trace;
			trace_summary_t sum;
			s        = $signed(raw);
			thr      = int'(threshold);
			in_trace = bin_pos < TRACE_BINS;
			if (in_trace && bin_pos >= int'(peak_start) && bin_pos <= int'(peak_end)
					&& s > 0 && s > int'(peak_run))
				peak_run = (s > int'(tpgq_pkg::PEAK_MAX)) ? tpgq_pkg::PEAK_MAX
				                                          : s[tpgq_pkg::AMP_W-1:0];
			if (in_trace && bin_pos >= int'(pulse_start) && bin_pos <= int'(pulse_end)) begin
				if (!armed && s > thr) begin
					armed = 1'b1;
					if (pulses != tpgq_pkg::COUNT_MAX)
						pulses = pulses + 1'b1;
				end else if (armed && 2 * s < thr) begin
					armed = 1'b0;
				end
			end
			if (in_trace)
				bin_pos++;
			if (!last)
				return;
			sum.peak   = peak_run;
			sum.count  = pulses;
			sum.single = (pulses == 1);
			sum.gated  = sum.single && peak_run >= gate_low && peak_run <= gate_high;
			trace_total = bump(trace_total);
			if (sum.single)
				single_total = bump(single_total);
			if (sum.gated)
				gated_total = bump(gated_total);
			sum.traces  = trace_total;
			sum.singles = single_total;
			sum.gateds  = gated_total;
			summaries_due = {summaries_due, sum};
			clear_trace();
		endfunction

		task report_mismatch(string what, longint got, longint want);
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
			mismatches++;
		endtask

		// Compare one transfer from the result stream with the oldest prediction
		task check_result(logic [tpgq_pkg::OUT_DATA_W-1:0] data, logic [1:0] flags);
			trace_summary_t want;
			if (summaries_due.size() == 0) begin
				report_mismatch("summary with none pending", 1, 0);
				return;
			end
			want = summaries_due.pop_front();
			summaries_checked++;
			if (want.single)
				single_summaries++;
			if (want.gated)
				gated_summaries++;
			if (data[11:0] !== want.peak)
				report_mismatch("trace_peak", data[11:0], want.peak);
			if (data[19:12] !== want.count)
				report_mismatch("pulse_count", data[19:12], want.count);
			if (flags[0] !== want.single)
				report_mismatch("single_pulse", flags[0], want.single);
			if (flags[1] !== want.gated)
				report_mismatch("in_gate", flags[1], want.gated);
			if (data[51:20] !== want.traces)
				report_mismatch("traces_seen", data[51:20], want.traces);
			if (data[83:52] !== want.singles)
				report_mismatch("single_seen", data[83:52], want.singles);
			if (data[115:84] !== want.gateds)
				report_mismatch("gated_seen", data[115:84], want.gateds);
		endtask
	endclass

	// Block inputs, all known from time zero
	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic [S_DATA_W-1:0]             s_tdata   = '0;   // [12:0] sample, [15:13] ignored by the block
	logic                            s_tlast   = 1'b0; // last_sample
	logic                            m_tready  = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic [2:0]                      cfg_index = '0;
	logic [tpgq_pkg::AMP_W-1:0]      cfg_data  = '0;
	logic                            s_tready, m_tvalid, cfg_ready;
	logic [tpgq_pkg::OUT_DATA_W-1:0] m_tdata;  // [11:0] peak, [19:12] count, [51:20] [83:52] [115:84] totals
	logic [1:0]                      m_tuser;  // [0] single_pulse, [1] in_gate

	trace_scoreboard sb = new();

	int tx_idle_pct    = 0;
	int rx_idle_pct    = 0;
	int stall_requests = 0;
	int samples_sent   = 0;
	int configs_used   = 0;

	trace_pulse_gate_qualifier #(
		.TRACE_LEN   (TRACE_BINS),
		.SAMPLE_BITS (SAMPLE_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs a handshake
	initial begin
		#5ms;
		$display("** trace_pulse_gate_qualifier: FAILED **");
		$finish;
	end

	// Result side: pick tready at each falling edge; honor a long hold-off on request
	initial begin : result_sink
		int served, hold_left;
		served    = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (stall_requests != served) begin
				served++;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
			end
		end
	end

	// Check every result transfer at the rising edge that completes it
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// Offer one sample, idling first at random; note it once the transfer happens
	task automatic send_sample(int s, bit last);
		logic [SAMPLE_W-1:0] raw;
		logic [2:0]          stray;
		raw   = s[SAMPLE_W-1:0];
		stray = 3'($urandom);
		@(negedge clk);
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {stray, raw};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(raw, last);
		samples_sent++;
	endtask

	// Drop tvalid and wait until every predicted summary has come out
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.summaries_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(tpgq_pkg::reg_index_t idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[tpgq_pkg::AMP_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_register(idx, value[tpgq_pkg::AMP_W-1:0]);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(int g_lo, int g_hi, int pk_s, int pk_e, int thr, int pw_s, int pw_e);
		write_register(tpgq_pkg::REG_GATE_LOW, g_lo);
		write_register(tpgq_pkg::REG_GATE_HIGH, g_hi);
		write_register(tpgq_pkg::REG_PEAK_WIN_START, pk_s);
		write_register(tpgq_pkg::REG_PEAK_WIN_END, pk_e);
		write_register(tpgq_pkg::REG_PULSE_THRESHOLD, thr);
		write_register(tpgq_pkg::REG_PULSE_WIN_START, pw_s);
		write_register(tpgq_pkg::REG_PULSE_WIN_END, pw_e);
		configs_used++;
	endtask

	// Windows sized for short traces; now and then empty or the whole range
	task automatic pick_window(output int first, output int final_bin);
		case ($urandom_range(9, 0))
			0: begin
				first     = $urandom_range(40, 10);
				final_bin = $urandom_range(first - 1, 0);
			end
			1: begin
				first     = 0;
				final_bin = 4095;  // upper bit drops, leaving the last bin
			end
			default: begin
				first     = $urandom_range(20, 0);
				final_bin = first + $urandom_range(40, 0);
			end
		endcase
	endtask

	task automatic random_config();
		int g_lo, g_hi, pk_s, pk_e, pw_s, pw_e, thr;
		case ($urandom_range(9, 0))
			0: begin
				g_lo = $urandom_range(4095, 1);
				g_hi = $urandom_range(g_lo - 1, 0);
			end
			1: begin
				g_lo = 0;
				g_hi = 4095;
			end
			default: begin
				g_lo = $urandom_range(1500, 0);
				g_hi = g_lo + $urandom_range(2000, 0);
			end
		endcase
		pick_window(pk_s, pk_e);
		pick_window(pw_s, pw_e);
		case ($urandom_range(9, 0))
			0: thr = 0;
			1: thr = 4095;
			default: thr = $urandom_range(1200, 1);
		endcase
		write_all(g_lo, g_hi, pk_s, pk_e, thr, pw_s, pw_e);
		// The spare index must leave every register alone
		if ($urandom_range(2, 0) == 0)
			write_register(tpgq_pkg::REG_UNUSED, $urandom_range(4095, 0));
	endtask

	function automatic int clip_sample(int s);
		if (s > 4095)
			return 4095;
		if (s < -4096)
			return -4096;
		return s;
	endfunction

	// One short trace: a lone shaped pulse, pulses hugging the arm and release
	// levels, full-range noise, or quiet baseline
	task automatic send_random_trace();
		int len, style, amp, at, s, thr, half;
		thr  = int'(sb.threshold);
		half = (thr + 1) / 2;
		case ($urandom_range(19, 0))
			0:       len = 1;
			1, 2, 3: len = $urandom_range(64, 25);
			default: len = $urandom_range(24, 2);
		endcase
		style = $urandom_range(3, 0);
		if (sb.gate_low <= sb.gate_high && $urandom_range(4, 0) < 3)
			amp = $urandom_range(int'(sb.gate_high), int'(sb.gate_low));
		else
			amp = $urandom_range(4095, 0);
		at = $urandom_range(len - 1, 0);
		for (int i = 0; i < len; i++) begin
			case (style)
				0: begin
					if (i == at)
						s = amp;
					else if (i == at + 1)
						s = amp / 2;
					else
						s = $urandom_range(20, 0) - 10;
				end
				1: begin
					case ($urandom_range(4, 0))
						0: s = thr + 1 + $urandom_range(50, 0);
						1: s = thr;
						2: s = half;          // just holds an armed pulse
						3: s = half - 1;      // just releases it
						default: s = $urandom_range(8191, 0) - 4096;
					endcase
				end
				2: s = $urandom_range(8191, 0) - 4096;
				default: s = $urandom_range(40, 0) - 20;
			endcase
			send_sample(clip_sample(s), i == len - 1);
		end
	endtask

	task automatic send_traces(int n);
		int start;
		start = samples_sent;
		while (samples_sent - start < n)
			send_random_trace();
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		tx_idle_pct = 14;
		rx_idle_pct = 59;

		// Directed: edge samples around a threshold of 1000 in small windows
		write_all(100, 2000, 2, 12, 1000, 1, 14);
		// most negative, most positive, arm just above, hold at half, release below half
		send_sample(-4096, 1'b0);
		send_sample(4095, 1'b0);
		send_sample(1001, 1'b0);
		send_sample(500, 1'b0);
		send_sample(499, 1'b0);
		send_sample(1000, 1'b0);
		send_sample(1001, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(0, 1'b0);
		send_sample(4095, 1'b1);
		// lone pulse with its peak inside the gate
		send_sample(0, 1'b0);
		send_sample(0, 1'b0);
		send_sample(1500, 1'b0);
		send_sample(200, 1'b0);
		send_sample(0, 1'b1);
		// one-sample trace, outside both windows
		send_sample(4095, 1'b1);
		// peak right on the upper gate edge
		send_sample(0, 1'b0);
		send_sample(0, 1'b0);
		send_sample(2000, 1'b0);
		send_sample(0, 1'b1);

		// Random traces in three idling regimes
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin tx_idle_pct = 14; rx_idle_pct = 59; end
				1: begin tx_idle_pct = 59; rx_idle_pct = 14; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int phase = 0; phase < 4; phase++) begin
				settle();
				if (phase == 0 && mode == 0) begin
					// everything open: zero threshold, full windows, full gate
					write_all(0, 4095, 0, 4095, 0, 0, 4095);
				end else if (phase == 0 && mode == 1) begin
					// everything closed: unreachable threshold, empty windows, inverted gate
					write_all(4095, 0, 2047, 0, 4095, 2047, 0);
				end else begin
					random_config();
				end
				if (mode == 0 && phase == 2) begin
					// pause the sender until the block has drained
					send_traces(28);
					settle();
					send_traces(28);
				end else begin
					// in one phase, a long receiver hold-off while samples keep coming
					if (mode == 2 && phase == 1)
						stall_requests++;
					send_traces(55);
				end
			end
		end

		// Pulse count saturation: power-on gate and threshold, both windows fully open
		settle();
		write_all(tpgq_pkg::GATE_LOW_RST, tpgq_pkg::GATE_HIGH_RST, 0, 2047,
			tpgq_pkg::PULSE_THRESHOLD_RST, 0, 2047);
		// alternate arm and release every bin, driving the count past its top
		for (int i = 0; i < 520; i++) begin
			if (i % 2 == 0)
				send_sample($urandom_range(3000, 201), i == 519);
			else
				send_sample($urandom_range(4195, 0) - 4096, i == 519);
		end

		settle();
		repeat (10) @(posedge clk);
		if (sb.summaries_due.size() != 0)
			sb.report_mismatch("summaries never delivered", 0, sb.summaries_due.size());

		$display("Covered %0d samples, %0d trace summaries over %0d register settings",
			samples_sent, sb.summaries_checked, configs_used);
		$display("  %0d single-pulse traces, %0d in gate, %0d mismatches",
			sb.single_summaries, sb.gated_summaries, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("** trace_pulse_gate_qualifier: PASSED **");
		end else begin
			$display("** trace_pulse_gate_qualifier: FAILED **");
		end
		$finish;
	end

endmodule

/* trace_pulse_gate_qualifier.f */
rtl/tpgq_pkg.sv
rtl/trace_pulse_gate_qualifier.sv
tb/sv/trace_pulse_gate_qualifier_test.sv
